// File: sv/cbsp_pkg.sv
// ----------------------------------------------------------------------------
// cbsp_pkg
// Shared types and constants of the camera block sync parser.
// ----------------------------------------------------------------------------
package cbsp_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned HuntW     = 8;
  localparam int unsigned NumFields = 5;
  localparam int unsigned IndexW    = 3;
  localparam int unsigned CfgIdxW   = 2;

  // Position of the last field word in the capture sequence (height).
  localparam logic [IndexW-1:0] LastIndex = 3'd5;

  localparam logic [WordW-1:0] SyncReset  = 16'hAA55;
  localparam logic             CheckReset = 1'b1;
  localparam logic [HuntW-1:0] HuntReset  = 8'd40;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgSyncWord    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCheckEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgHuntLimit   = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNCHANGED = 3'd1,
    ST_BUS       = 3'd2,
    ST_NOSYNC    = 3'd3,
    ST_CHECKSUM  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_CAPTURE = 2'd2
  } phase_e;

  typedef struct packed {
    logic [WordW-1:0] rx_word;
    logic             bus_error;
  } in_t;

  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] signature;
    logic [WordW-1:0] pos_x;
    logic [WordW-1:0] pos_y;
    logic [WordW-1:0] obj_width;
    logic [WordW-1:0] obj_height;
  } out_t;

  typedef struct packed {
    logic [WordW-1:0] sync_word;
    logic             check_enable;
    logic [HuntW-1:0] hunt_limit;
  } cfg_t;

endpackage

// File: sv/cbsp_core.sv
// ----------------------------------------------------------------------------
// cbsp_core
// Frame state machine: sync hunt, second sync, capture and checksum test.
// ----------------------------------------------------------------------------
module cbsp_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  cbsp_pkg::in_t  word_i,
  input  cbsp_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  output cbsp_pkg::out_t res_o
);

  cbsp_pkg::phase_e                    phase_q, phase_d;
  logic [cbsp_pkg::HuntW-1:0]          hunt_q, hunt_d;
  logic [cbsp_pkg::IndexW-1:0]         idx_q, idx_d;
  logic [cbsp_pkg::WordW-1:0]          sum_q, sum_d;
  logic [cbsp_pkg::NumFields-1:0][cbsp_pkg::WordW-1:0] fields_q, fields_d;

  logic [cbsp_pkg::WordW-1:0]  w;
  logic [cbsp_pkg::WordW-1:0]  field_sum;
  logic [cbsp_pkg::HuntW:0]    hunt_next;
  logic [cbsp_pkg::IndexW-1:0] slot;
  logic                        emit;
  cbsp_pkg::status_e           status;

  assign w         = word_i.bus_error ? '0 : word_i.rx_word;
  assign hunt_next = {1'b0, hunt_q} + {{cbsp_pkg::HuntW{1'b0}}, 1'b1};
  assign slot      = idx_q - 3'd1;
  // The last word (height) enters the sum directly, the others from the store.
  assign field_sum = fields_q[0] + fields_q[1] + fields_q[2] + fields_q[3] + w;

  always_comb begin
    phase_d  = phase_q;
    hunt_d   = hunt_q;
    idx_d    = idx_q;
    sum_d    = sum_q;
    fields_d = fields_q;
    emit     = 1'b0;
    status   = cbsp_pkg::ST_OK;
    case (phase_q)
      cbsp_pkg::PH_SYNC2: begin
        if (w == cfg_i.sync_word) begin
          phase_d = cbsp_pkg::PH_CAPTURE;
          idx_d   = '0;
        end else begin
          emit   = 1'b1;
          status = cbsp_pkg::ST_UNCHANGED;
        end
      end
      cbsp_pkg::PH_CAPTURE: begin
        if (idx_q == '0) begin
          sum_d = w;
        end else begin
          fields_d[slot] = w;
        end
        if (idx_q != cbsp_pkg::LastIndex) begin
          idx_d = idx_q + 3'd1;
        end else begin
          emit = 1'b1;
          if (cfg_i.check_enable && (field_sum != sum_q)) begin
            fields_d = '0;
            status   = cbsp_pkg::ST_CHECKSUM;
          end else begin
            status = cbsp_pkg::ST_OK;
          end
        end
      end
      default: begin
        if (w == cfg_i.sync_word) begin
          phase_d = cbsp_pkg::PH_SYNC2;
          hunt_d  = '0;
        end else if (hunt_next >= {1'b0, cfg_i.hunt_limit}) begin
          fields_d = '0;
          emit     = 1'b1;
          status   = cbsp_pkg::ST_NOSYNC;
        end else begin
          hunt_d = hunt_next[cbsp_pkg::HuntW-1:0];
          if (word_i.bus_error) begin
            emit   = 1'b1;
            status = cbsp_pkg::ST_BUS;
          end
        end
      end
    endcase
    // Every finished attempt starts a fresh hunt.
    if (emit) begin
      phase_d = cbsp_pkg::PH_HUNT;
      hunt_d  = '0;
      idx_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= cbsp_pkg::PH_HUNT;
      hunt_q   <= '0;
      idx_q    <= '0;
      sum_q    <= '0;
      fields_q <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      hunt_q   <= hunt_d;
      idx_q    <= idx_d;
      sum_q    <= sum_d;
      fields_q <= fields_d;
    end
  end

  assign res_valid_o      = emit;
  assign res_o.status     = status;
  assign res_o.signature  = fields_d[0];
  assign res_o.pos_x      = fields_d[1];
  assign res_o.pos_y      = fields_d[2];
  assign res_o.obj_width  = fields_d[3];
  assign res_o.obj_height = fields_d[4];

endmodule

// File: sv/camera_block_sync_parser_unit.sv
// ----------------------------------------------------------------------------
// camera_block_sync_parser_unit
// Parses the object block stream of a vision camera, one 16-bit word a request.
// ----------------------------------------------------------------------------
// The unit takes one received word per cycle unless it stalls the input, and
// returns one status request whenever a frame attempt ends: a good frame, a
// missing second sync, a bus error or an exhausted sync hunt, or a checksum
// mismatch. Each word passes an input register, is handled combinationally
// by the frame state machine, and the status it produces is written into the
// result register. Words can follow in every cycle while nothing stalls.
// The result register lets a new word enter while a status still waits
// downstream; the input side stalls only when a word is held in the input
// register while a status sits in the result register and is stalled
// downstream. Configuration writes are always ready and take effect at once;
// they are meant to happen while no frame is in flight.
// After a no-sync or checksum error the reported object fields read as zero.
module camera_block_sync_parser_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Word input channel.
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  cbsp_pkg::in_t                 in_data_i,
  // Status output channel.
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output cbsp_pkg::out_t                out_data_o,
  // Configuration write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cbsp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cbsp_pkg::WordW-1:0]    cfg_data_i
);

  cbsp_pkg::cfg_t cfg_q;
  logic           s1_valid_q;
  cbsp_pkg::in_t  s1_data_q;
  logic           out_valid_q;
  cbsp_pkg::out_t out_data_q;
  logic           out_free;
  logic           fire;
  logic           res_valid;
  cbsp_pkg::out_t res;

  // Configuration registers; writes are accepted in every cycle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_word    <= cbsp_pkg::SyncReset;
      cfg_q.check_enable <= cbsp_pkg::CheckReset;
      cfg_q.hunt_limit   <= cbsp_pkg::HuntReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cbsp_pkg::CfgSyncWord:    cfg_q.sync_word    <= cfg_data_i;
        cbsp_pkg::CfgCheckEnable: cfg_q.check_enable <= cfg_data_i[0];
        cbsp_pkg::CfgHuntLimit:   cfg_q.hunt_limit   <= cfg_data_i[cbsp_pkg::HuntW-1:0];
        default: ;
      endcase
    end
  end

  // The held word is handled when the result register can take a status.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_data_q <= in_data_i;
    end
  end

  cbsp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .word_i      (s1_data_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // A stall is only raised while a word is held in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  // A status produced by the state machine is presented on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && res_valid) |=> out_valid_o)
    else $error("status request lost");

  // Error statuses that clear the fields report all fields as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_data_o.status == cbsp_pkg::ST_NOSYNC) ||
                     (out_data_o.status == cbsp_pkg::ST_CHECKSUM)))
    |-> ((out_data_o.signature == '0) && (out_data_o.pos_x == '0) &&
         (out_data_o.pos_y == '0) && (out_data_o.obj_width == '0) &&
         (out_data_o.obj_height == '0)))
    else $error("fields not cleared on error status");
`endif

endmodule

// File: tb/camera_block_sync_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// camera_block_sync_parser_unit_tb
// Self-checking bench for the camera block sync parser.
// ----------------------------------------------------------------------------
// Words are fed through the stall handshake. A behavioral copy of the frame
// state machine runs beside the unit and predicts every status request. Each
// status the unit hands out is compared field by field with the oldest
// prediction. Directed frames come first, then random traffic under several
// register settings, with random gaps and stalls on both channels.
module camera_block_sync_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [cbsp_pkg::WordW-1:0] word_t;
  typedef logic [cbsp_pkg::HuntW-1:0] hunt_t;

  localparam int CycleLimit  = 200000;
  localparam int IdlePct     = 34;
  // A word passes the input register and then the result register on its way
  // to a status, so the drain wait covers everything still in flight.
  localparam int DrainCycles = 6;

  logic                            clk_i;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_stall_o;
  cbsp_pkg::in_t                   in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_stall_i = 1'b0;
  cbsp_pkg::out_t                  out_data_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [cbsp_pkg::CfgIdxW-1:0]    cfg_index_i = '0;
  word_t                           cfg_data_i  = '0;

  // Bench copy of the register settings.
  word_t                           sync_cfg  = cbsp_pkg::SyncReset;
  logic                            check_cfg = cbsp_pkg::CheckReset;
  hunt_t                           limit_cfg = cbsp_pkg::HuntReset;

  // Bench copy of the frame state machine.
  cbsp_pkg::phase_e                hunt_phase   = cbsp_pkg::PH_HUNT;
  hunt_t                           hunt_run     = '0;
  logic [cbsp_pkg::IndexW-1:0]     capture_pos  = '0;
  word_t                           frame_sum    = '0;
  word_t                           object_fields [cbsp_pkg::NumFields] = '{default: '0};

  cbsp_pkg::out_t                  pending_status [$];
  int                              mismatches = 0;
  int                              words_sent = 0;
  int                              cycles     = 0;
  // While set, neither side idles or stalls.
  bit                              calm       = 1'b0;

  camera_block_sync_parser_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Hard stop in case the unit hangs.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic flag_mismatch(string what, word_t got, word_t want);
    $display("tb: %s: got %h, want %h", what, got, want);
    mismatches++;
  endtask

  // Queues the status of an ended frame attempt and rearms the hunt. The
  // object fields are wiped first for the no-sync and checksum outcomes.
  task automatic post_status(cbsp_pkg::status_e st, bit wipe);
    cbsp_pkg::out_t res;
    if (wipe) begin
      foreach (object_fields[i]) object_fields[i] = '0;
    end
    res.status     = st;
    res.signature  = object_fields[0];
    res.pos_x      = object_fields[1];
    res.pos_y      = object_fields[2];
    res.obj_width  = object_fields[3];
    res.obj_height = object_fields[4];
    pending_status.push_back(res);
    hunt_phase  = cbsp_pkg::PH_HUNT;
    hunt_run    = '0;
    capture_pos = '0;
  endtask

  // Advances the bench state machine by one accepted word.
  task automatic parse_word(cbsp_pkg::in_t item);
    word_t w;
    word_t total;
    int    next_run;
    // A failed transfer reads as zero.
    w = item.bus_error ? '0 : item.rx_word;
    case (hunt_phase)
      cbsp_pkg::PH_SYNC2: begin
        if (w == sync_cfg) begin
          hunt_phase  = cbsp_pkg::PH_CAPTURE;
          capture_pos = '0;
        end else begin
          post_status(cbsp_pkg::ST_UNCHANGED, 1'b0);
        end
      end
      cbsp_pkg::PH_CAPTURE: begin
        if (capture_pos == '0) frame_sum = w;
        else object_fields[capture_pos - 1'b1] = w;
        if (capture_pos < cbsp_pkg::LastIndex) begin
          capture_pos++;
        end else begin
          total = '0;
          foreach (object_fields[i]) total += object_fields[i];
          if (check_cfg && total != frame_sum) post_status(cbsp_pkg::ST_CHECKSUM, 1'b1);
          else post_status(cbsp_pkg::ST_OK, 1'b0);
        end
      end
      default: begin
        if (w == sync_cfg) begin
          hunt_phase = cbsp_pkg::PH_SYNC2;
          hunt_run   = '0;
        end else begin
          // The limit wins over a bus error; a limit of zero acts like one.
          next_run = int'(hunt_run) + 1;
          if (next_run >= int'(limit_cfg)) begin
            post_status(cbsp_pkg::ST_NOSYNC, 1'b1);
          end else begin
            hunt_run = hunt_t'(next_run);
            if (item.bus_error) post_status(cbsp_pkg::ST_BUS, 1'b0);
          end
        end
      end
    endcase
  endtask

  // Presents one word, holds it until the unit takes the request, then
  // maybe leaves a random gap.
  task automatic send_word(word_t word, logic err);
    cbsp_pkg::in_t item;
    item.rx_word   = word;
    item.bus_error = err;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    parse_word(item);
    words_sent++;
    if (!calm && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < IdlePct);
    end
  endtask

  // The sender holds off until every predicted status has come back and
  // the pipeline has settled.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Writes all three registers back to back while the unit is idle.
  task automatic load_settings(word_t sync, logic chk, hunt_t limit);
    logic [cbsp_pkg::CfgIdxW-1:0] regs [3];
    word_t                        vals [3];
    regs = '{cbsp_pkg::CfgSyncWord, cbsp_pkg::CfgCheckEnable, cbsp_pkg::CfgHuntLimit};
    vals = '{sync, {15'd0, chk}, {8'd0, limit}};
    drain_results();
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= regs[i];
      cfg_data_i  <= vals[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    sync_cfg  = sync;
    check_cfg = chk;
    limit_cfg = limit;
  endtask

  function automatic word_t field_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic word_t noise_word();
    word_t v;
    v = word_t'($urandom);
    if (v == sync_cfg) v = ~v;
    return v;
  endfunction

  // Sends a full block: two syncs, the checksum, then the five fields.
  // err_mask bit 0 marks the checksum word, bits 1 to 5 the fields; the
  // checksum is built over what the unit will see, then offset.
  task automatic send_frame(word_t fields [cbsp_pkg::NumFields],
                            word_t sum_offset, logic [5:0] err_mask);
    word_t total;
    bit    sync_err;
    total = '0;
    for (int i = 0; i < cbsp_pkg::NumFields; i++) begin
      if (!err_mask[i+1]) total += fields[i];
    end
    // With a sync word of zero a failed transfer also counts as sync.
    repeat (2) begin
      sync_err = (sync_cfg == '0) && ($urandom_range(1) == 1);
      send_word(sync_err ? word_t'($urandom) : sync_cfg, sync_err);
    end
    send_word(total + sum_offset, err_mask[0]);
    for (int i = 0; i < cbsp_pkg::NumFields; i++) send_word(fields[i], err_mask[i+1]);
  endtask

  // Reset settings: good, bad and damaged frames, a missing second sync and bus errors while hunting.
  task automatic test_frame_cases();
    word_t f [cbsp_pkg::NumFields];
    // Extreme fields; the checksum wraps around several times.
    f = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0001};
    send_frame(f, '0, '0);
    f = '{16'h1234, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00};
    send_frame(f, 16'h0001, '0);
    // A failed transfer inside the block just reads as zero.
    send_frame(f, '0, 6'b000100);
    // Second sync missing.
    send_word(sync_cfg, 1'b0);
    send_word(~sync_cfg, 1'b0);
    // Bus errors while hunting, one of them on a word that carries sync.
    send_word(16'hFFFF, 1'b1);
    send_word(sync_cfg, 1'b1);
  endtask

  // Hunt limit at one, at zero and at two.
  task automatic test_hunt_limit();
    load_settings(cbsp_pkg::SyncReset, 1'b1, 8'd1);
    send_word(noise_word(), 1'b0);
    send_word(noise_word(), 1'b1);
    load_settings(cbsp_pkg::SyncReset, 1'b1, 8'd0);
    send_word(noise_word(), 1'b0);
    load_settings(cbsp_pkg::SyncReset, 1'b1, 8'd2);
    send_word(noise_word(), 1'b1);
    send_word(noise_word(), 1'b0);
    send_word(noise_word(), 1'b1);
  endtask

  // Sync word of zero with the checksum check switched off.
  task automatic test_zero_sync();
    word_t f [cbsp_pkg::NumFields];
    load_settings('0, 1'b0, cbsp_pkg::HuntReset);
    f = '{16'h0001, 16'h0002, 16'h0003, 16'h0004, 16'h0005};
    send_frame(f, 16'h1234, '0);
    send_word(16'hBEEF, 1'b1);
    send_word(16'h0001, 1'b0);
  endtask

  // Mostly well-formed blocks with random content, mixed with broken
  // blocks, bus errors and line noise.
  task automatic run_random_phase(int count, bit steady);
    word_t f [cbsp_pkg::NumFields];
    int    stop_at;
    int    pick;
    calm    = steady;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 2) begin
        drain_results();
      end else if (pick < 65) begin
        repeat ($urandom_range(2)) send_word(noise_word(), 1'b0);
        foreach (f[i]) f[i] = field_value();
        send_frame(f, ($urandom_range(9) == 0) ? word_t'($urandom_range(1, 65535)) : '0,
                   ($urandom_range(5) == 0) ? 6'($urandom) : '0);
      end else if (pick < 75) begin
        send_word(sync_cfg, 1'b0);
        send_word(noise_word(), 1'b0);
      end else if (pick < 85) begin
        send_word(word_t'($urandom), 1'b1);
      end else begin
        send_word(word_t'($urandom), $urandom_range(7) == 0);
      end
    end
    calm = 1'b0;
  endtask

  task automatic test_random_traffic();
    run_random_phase(150, 1'b0);
    load_settings('0, 1'b0, 8'd1);
    run_random_phase(100, 1'b0);
    // Widest hunt window, exhausted once on purpose.
    load_settings('1, 1'b1, 8'd255);
    repeat (260) send_word(noise_word(), 1'b0);
    run_random_phase(100, 1'b0);
    // A long stretch at full rate on both sides.
    load_settings(word_t'($urandom), 1'($urandom), hunt_t'($urandom_range(2, 12)));
    run_random_phase(150, 1'b1);
    load_settings(word_t'($urandom), 1'b1, 8'd3);
    run_random_phase(100, 1'b0);
  endtask

  // The status side stalls at random and checks every request it takes.
  always @(posedge clk_i) begin : status_check
    cbsp_pkg::out_t want;
    out_stall_i <= !calm && ($urandom_range(99) < IdlePct);
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_status.size() == 0) begin
        flag_mismatch("status with none pending", word_t'(out_data_o.status), '0);
      end else begin
        want = pending_status.pop_front();
        if (out_data_o.status != want.status)
          flag_mismatch("status", word_t'(out_data_o.status), word_t'(want.status));
        if (out_data_o.signature != want.signature)
          flag_mismatch("signature", out_data_o.signature, want.signature);
        if (out_data_o.pos_x != want.pos_x)
          flag_mismatch("pos_x", out_data_o.pos_x, want.pos_x);
        if (out_data_o.pos_y != want.pos_y)
          flag_mismatch("pos_y", out_data_o.pos_y, want.pos_y);
        if (out_data_o.obj_width != want.obj_width)
          flag_mismatch("obj_width", out_data_o.obj_width, want.obj_width);
        if (out_data_o.obj_height != want.obj_height)
          flag_mismatch("obj_height", out_data_o.obj_height, want.obj_height);
      end
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_frame_cases();
    test_hunt_limit();
    test_zero_sync();
    test_random_traffic();
    drain_results();
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
